FILE: hdl/isotropic_tv_sum_unit_assert.svh
// Assertion macros for the isotropic TV sum block
`ifndef ISOTROPIC_TV_SUM_UNIT_ASSERT_SVH
`define ISOTROPIC_TV_SUM_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define ITV_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// implication checked in the next cycle
`define ITV_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: hdl/itv_pkg.sv
// ----------------------------------------------------------------------------
// itv_pkg
// Shared constants of the isotropic TV sum block.
// ----------------------------------------------------------------------------
package itv_pkg;
  localparam int unsigned SumBits   = 52;
  localparam int unsigned DepthMax  = 1024;
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegDepth  = 2'd2;
endpackage

FILE: hdl/isotropic_tv_sum_unit.sv
// Isotropic TV sum: each voxel is read against the plane store (one RAM),
// then up to three gradient terms run in turn through a radix-2 square root
// unit (26 iterations). A new voxel is accepted only once the last one has
// finished its terms; the sum word is registered as the last voxel finishes.
// Reset is asynchronous active low and clears control, config, position, sum
// and valid registers, but not the plane store, sample, radicand or output word.
// ----------------------------------------------------------------------------
// isotropic_tv_sum_unit
// Streaming 3D isotropic total variation with a circular plane store.
// ----------------------------------------------------------------------------
module isotropic_tv_sum_unit #(
  parameter int unsigned MAX_WIDTH   = 256,
  parameter int unsigned MAX_HEIGHT  = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] voxel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [51:0] tv_total_o
);
  import itv_pkg::*;
  `include "isotropic_tv_sum_unit_assert.svh"

  localparam int unsigned XB = $clog2(MAX_WIDTH);
  localparam int unsigned YB = $clog2(MAX_HEIGHT);
  localparam int unsigned AB = XB + YB;
  localparam int unsigned DB = SAMPLE_BITS + 1;
  localparam int unsigned QB = 2 * DB + 2;
  localparam int unsigned RB = (QB + 16 + 1) / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_E, S_WAIT, S_TERM,
    S_ROOT, S_FIN
  } state_e;

  state_e state_q;
  logic [8:0]  w_cfg_q, h_cfg_q;
  logic [10:0] d_cfg_q;
  logic [XB:0] x_q;
  logic [YB:0] y_q;
  logic [10:0] z_q;
  logic [SumBits-1:0] sum_q, out_q;
  logic        out_v_q;
  logic signed [SAMPLE_BITS-1:0] cur_q, ra_q, rb_q, rc_q, rd_q, re_q, rdata_q;
  logic [1:0]  term_q;
  logic [QB-1:0] rad_q;
  logic        start_q;

  logic signed [SAMPLE_BITS-1:0] mem [2**AB];
  logic [AB-1:0] raddr, waddr;
  logic          wen;

  // clamped dimensions
  logic [12:0] w_eff, h_eff, d_eff;
  always_comb begin
    w_eff = (w_cfg_q == '0) ? 13'd1 : (13'(w_cfg_q) > 13'(MAX_WIDTH) ?
            13'(MAX_WIDTH) : 13'(w_cfg_q));
    h_eff = (h_cfg_q == '0) ? 13'd1 : (13'(h_cfg_q) > 13'(MAX_HEIGHT) ?
            13'(MAX_HEIGHT) : 13'(h_cfg_q));
    d_eff = (d_cfg_q == '0) ? 13'd1 : (13'(d_cfg_q) > 13'(DepthMax) ?
            13'(DepthMax) : 13'(d_cfg_q));
  end

  logic last_pl, x_edge, y_edge, last_vox;
  assign last_pl  = (13'(z_q) + 13'd1 == d_eff);
  assign x_edge   = (13'(x_q) + 13'd1 >= w_eff);
  assign y_edge   = (13'(y_q) + 13'd1 >= h_eff);
  assign last_vox = last_pl && x_edge && y_edge;

  function automatic logic [AB-1:0] addr(input logic [XB:0] x, input logic [YB:0] y);
    return {y[YB-1:0], x[XB-1:0]};
  endfunction

  always_comb begin
    raddr = addr(x_q, y_q);
    unique case (state_q)
      S_RD_A: raddr = addr(x_q, y_q);
      S_RD_B: raddr = addr(x_q + 1'b1, y_q);
      S_RD_C: raddr = addr(x_q, y_q + 1'b1);
      S_RD_D: raddr = addr(x_q, y_q - 1'b1);
      S_RD_E: raddr = addr(x_q + 1'b1, y_q - 1'b1);
      default: raddr = addr(x_q - 1'b1, y_q);
    endcase
  end
  assign waddr = addr(x_q, y_q);
  assign wen   = (state_q == S_FIN);

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= cur_q;
    rdata_q <= mem[raddr];
  end

  function automatic logic [QB-1:0] sq(input logic signed [SAMPLE_BITS-1:0] p,
                                       input logic signed [SAMPLE_BITS-1:0] q);
    logic signed [DB-1:0] d;
    logic [DB-1:0] a;
    d = DB'(p) - DB'(q);
    a = d[DB-1] ? DB'(-d) : DB'(d);
    return QB'(a * a);
  endfunction

  logic          sq_busy, sq_done;
  logic [RB-1:0] root;
  itv_sqrt #(.InBits(QB)) u_sqrt (
    .clk_i, .rst_ni, .start_i(start_q), .rad_i(rad_q),
    .busy_o(sq_busy), .done_o(sq_done), .root_o(root)
  );

  logic [SumBits:0] sum_add;
  assign sum_add = {1'b0, sum_q} + (SumBits+1)'(root);

  // radicand for the pending term
  logic [QB-1:0] rad_sel;
  logic signed [SAMPLE_BITS-1:0] zero_s;
  assign zero_s = '0;
  always_comb begin
    case (term_q)
      2'd0: rad_sel = (x_edge ? QB'(0) : sq(ra_q, rb_q)) +
                      (y_edge ? QB'(0) : sq(ra_q, rc_q)) + sq(ra_q, cur_q);
      2'd1: rad_sel = (x_edge ? QB'(0) : sq(rd_q, re_q)) + sq(rd_q, cur_q);
      default: rad_sel = sq(rdata_q, cur_q) + sq(zero_s, zero_s);
    endcase
  end

  logic need0, need1, need2;
  assign need0 = (z_q != '0);
  assign need1 = last_pl && (y_q != '0);
  assign need2 = last_pl && y_edge && (x_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      w_cfg_q <= 9'd256; h_cfg_q <= 9'd256; d_cfg_q <= 11'd1;
      x_q <= '0; y_q <= '0; z_q <= '0; sum_q <= '0;
      out_v_q <= 1'b0; start_q <= 1'b0; term_q <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (cfg_we_i && (cfg_idx_i == RegWidth || cfg_idx_i == RegHeight ||
                       cfg_idx_i == RegDepth)) begin
        if (cfg_idx_i == RegWidth)  w_cfg_q <= cfg_data_i[8:0];
        if (cfg_idx_i == RegHeight) h_cfg_q <= cfg_data_i[8:0];
        if (cfg_idx_i == RegDepth)  d_cfg_q <= cfg_data_i;
        x_q <= '0; y_q <= '0; z_q <= '0; sum_q <= '0;
      end
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          // keep the low sample bits, drop the rest
          cur_q   <= SAMPLE_BITS'($unsigned(voxel_i));
          state_q <= S_RD_A;
        end
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: begin ra_q <= rdata_q; state_q <= S_RD_C; end
        S_RD_C: begin rb_q <= rdata_q; state_q <= S_RD_D; end
        S_RD_D: begin rc_q <= rdata_q; state_q <= S_RD_E; end
        S_RD_E: begin rd_q <= rdata_q; state_q <= S_WAIT; end
        S_WAIT: begin
          re_q <= rdata_q;
          term_q <= 2'd0;
          state_q <= S_TERM;
        end
        S_TERM: begin
          // issue next needed term, or finish
          if ((term_q == 2'd0 && need0) || (term_q == 2'd1 && need1) ||
              (term_q == 2'd2 && need2)) begin
            rad_q   <= rad_sel;
            start_q <= 1'b1;
            state_q <= S_ROOT;
          end else if (term_q == 2'd2) begin
            state_q <= S_FIN;
          end else begin
            term_q <= term_q + 1'b1;
          end
        end
        S_ROOT: if (sq_done) begin
          sum_q <= sum_add[SumBits] ? '1 : sum_add[SumBits-1:0];
          if (term_q == 2'd2) state_q <= S_FIN;
          else begin term_q <= term_q + 1'b1; state_q <= S_TERM; end
        end
        S_FIN: if (!out_v_q || !out_stall_i) begin
          state_q <= S_IDLE;
          if (last_vox) begin
            out_q <= sum_q; out_v_q <= 1'b1;
            x_q <= '0; y_q <= '0; z_q <= '0; sum_q <= '0;
          end else if (!x_edge) x_q <= x_q + 1'b1;
          else begin
            x_q <= '0;
            if (!y_edge) y_q <= y_q + 1'b1;
            else begin y_q <= '0; z_q <= z_q + 1'b1; end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign tv_total_o  = out_q;

  `ITV_ASSERT_IMP(a_root_in_term, clk_i, rst_ni, sq_done, state_q == S_ROOT)
  `ITV_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_q, sq_busy)
  `ITV_ASSERT_IMP(a_accept_idle, clk_i, rst_ni, in_valid_i && !in_stall_o,
                  !sq_busy)
endmodule

FILE: hdl/itv_sqrt.sv
// ----------------------------------------------------------------------------
// itv_sqrt
// Sequential square root: floor(sqrt(s * 65536)), two radicand bits per cycle.
// ----------------------------------------------------------------------------
module itv_sqrt #(
  parameter int unsigned InBits = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [InBits-1:0] rad_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [(InBits+16+1)/2-1:0] root_o
);
  localparam int unsigned RadBits = ((InBits + 16 + 1) / 2) * 2;
  localparam int unsigned RootBits = RadBits / 2;
  localparam int unsigned CntBits = $clog2(RootBits + 1);

  logic [RadBits-1:0]  rad_q;
  logic [RootBits+1:0] rem_q;
  logic [RootBits-1:0] root_q;
  logic [CntBits-1:0]  cnt_q;
  logic                busy_q, done_q;

  logic [RootBits+1:0] rem_sh, trial;
  assign rem_sh = {rem_q[RootBits-1:0], rad_q[RadBits-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(RootBits);
        rad_q  <= {rad_i, 16'd0} << (RadBits - InBits - 16);
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q <= rad_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootBits-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootBits-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;
endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for isotropic_tv_sum_unit: a directed table, then
// random volumes across many sizes, checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itv_pkg::*;

  typedef enum logic {RowCfg, RowVox} row_kind_e;
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxBits-1:0] idx;
    logic [10:0]          data;
    logic signed [15:0]   vox;
    bit                   has_total;
    longint unsigned      total;
  } stim_row_t;

  localparam int unsigned DrainCycles = 250;
  localparam longint unsigned SumCap = (64'd1 << SumBits) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [10:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic signed [15:0] voxel_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [51:0] tv_total_o;

  isotropic_tv_sum_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .voxel_i    (voxel_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tv_total_o (tv_total_o)
  );

  // predictor state
  int              vol_store [65536];
  int unsigned     reg_w, reg_h, reg_d;
  int unsigned     pos_x, pos_y, pos_z;
  longint unsigned acc_sum;

  longint unsigned totals_due[$];
  int              fail_count;
  int              words_sent;
  int              totals_seen;
  int              send_idle_pct;
  int              recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("timeout at %0t", $time);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // floor(256*sqrt(s)) as the integer root of s*65536
  function automatic longint unsigned scaled_mag(longint unsigned s);
    longint unsigned n;
    longint unsigned r;
    longint unsigned t;
    n = s << 16;
    r = 0;
    for (int b = 30; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic void add_mag(longint a, longint b, longint c);
    acc_sum += scaled_mag(a * a + b * b + c * c);
    if (acc_sum > SumCap) acc_sum = SumCap;
  endfunction

  function automatic void restart_volume();
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    acc_sum = 0;
  endfunction

  // advance the predictor by one voxel; returns 1 when the total is due
  function automatic bit tv_take(logic signed [15:0] v, output longint unsigned tot);
    int unsigned w, h, d;
    bit          last_pl;
    longint      cur, a, b, dw, dh;
    w = clamp_dim(reg_w, 256);
    h = clamp_dim(reg_h, 256);
    d = clamp_dim(reg_d, DepthMax);
    cur = v;
    last_pl = (pos_z + 1 == d);
    tot = 0;
    if (pos_z >= 1) begin
      a = vol_store[pos_y * 256 + pos_x];
      dw = (pos_x + 1 < w) ? a - vol_store[pos_y * 256 + pos_x + 1] : 0;
      dh = (pos_y + 1 < h) ? a - vol_store[(pos_y + 1) * 256 + pos_x] : 0;
      add_mag(dw, dh, a - cur);
    end
    if (last_pl && pos_y >= 1) begin
      b = vol_store[(pos_y - 1) * 256 + pos_x];
      dw = (pos_x + 1 < w) ? b - vol_store[(pos_y - 1) * 256 + pos_x + 1] : 0;
      add_mag(dw, b - cur, 0);
    end
    if (last_pl && pos_y + 1 == h && pos_x >= 1)
      add_mag(vol_store[pos_y * 256 + pos_x - 1] - cur, 0, 0);
    vol_store[pos_y * 256 + pos_x] = int'(cur);
    if (last_pl && pos_y + 1 == h && pos_x + 1 == w) begin
      tot = acc_sum;
      restart_volume();
      return 1'b1;
    end
    if (pos_x + 1 < w) begin
      pos_x++;
    end else begin
      pos_x = 0;
      if (pos_y + 1 < h) begin
        pos_y++;
      end else begin
        pos_y = 0;
        pos_z++;
      end
    end
    return 1'b0;
  endfunction

  // receiver: random stall, compare each word with the oldest expected total
  always @(posedge clk_i) begin
    longint unsigned want;
    if (out_valid_o && !out_stall_i) begin
      totals_seen++;
      if (totals_due.size() == 0) begin
        $display("%0t: unexpected tv_total %0d", $time, tv_total_o);
        fail_count++;
      end else begin
        want = totals_due.pop_front();
        if (tv_total_o !== want[51:0]) begin
          $display("%0t: tv_total expected %0d actual %0d", $time, want, tv_total_o);
          fail_count++;
        end
      end
    end
    if (rst_ni)
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // lower valid and hold until every total is in, then let the block settle
  task automatic drain_quiet();
    in_valid_i <= 1'b0;
    do begin
      while (totals_due.size() != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end while (totals_due.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [10:0] data);
    drain_quiet();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegWidth:  reg_w = data[8:0];
      RegHeight: reg_h = data[8:0];
      RegDepth:  reg_d = data;
      default: ;
    endcase
    restart_volume();
  endtask

  task automatic set_volume(int unsigned w, int unsigned h, int unsigned d);
    write_reg(RegWidth, 11'(w));
    write_reg(RegHeight, 11'(h));
    write_reg(RegDepth, 11'(d));
  endtask

  // send one word; a typed total overrides the predictor's expectation
  task automatic send_word(logic signed [15:0] v, bit has_total = 0,
                           longint unsigned total = 0);
    longint unsigned tot;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    voxel_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    if (tv_take(v, tot)) totals_due.push_back(has_total ? total : tot);
  endtask

  function automatic logic signed [15:0] rand_voxel();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(rand_voxel());
  endtask

  stim_row_t dir_rows[$];

  initial begin
    int unsigned w, h, d, vol_len, mode_start;
    bit          paused;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegWidth;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    voxel_i = '0;
    out_stall_i = 1'b0;
    fail_count = 0;
    words_sent = 0;
    totals_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_w = 256;
    reg_h = 256;
    reg_d = 1;
    restart_volume();
    foreach (vol_store[i]) vol_store[i] = 0;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single voxel, edges in each axis, out-of-range sizes, a small cube
    dir_rows = '{
      '{RowCfg, RegWidth,  11'd1, 16'sd0, 0, 0},
      '{RowCfg, RegHeight, 11'd1, 16'sd0, 0, 0},
      '{RowCfg, RegDepth,  11'd1, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd123, 1, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd32768, 1, 0},
      '{RowCfg, RegWidth,  11'd2, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd32767, 0, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd32768, 1, 16776960},
      '{RowCfg, RegWidth,  11'd0, 16'sd0, 0, 0},
      '{RowCfg, RegHeight, 11'd2, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd32768, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd32767, 1, 16776960},
      '{RowCfg, RegHeight, 11'd0, 16'sd0, 0, 0},
      '{RowCfg, RegDepth,  11'd2, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd1, 1, 256},
      '{RowCfg, RegWidth,  11'd2, 16'sd0, 0, 0},
      '{RowCfg, RegHeight, 11'd2, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd100, 0, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd7, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd32767, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd4, 0, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd32768, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd55, 0, 0},
      '{RowVox, RegWidth,  11'd0, -16'sd1000, 0, 0},
      '{RowCfg, RegDepth,  11'd0, 16'sd0, 0, 0},
      '{RowCfg, RegHeight, 11'd1, 16'sd0, 0, 0},
      '{RowCfg, RegWidth,  11'd3, 16'sd0, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd5, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd2, 0, 0},
      '{RowVox, RegWidth,  11'd0, 16'sd2, 1, 768}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg)
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        send_word(dir_rows[i].vox, dir_rows[i].has_total, dir_rows[i].total);
    end

    // random small volumes under three idle patterns
    paused = 1'b0;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 60 : 0;
      recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 14 : 0;
      mode_start = words_sent;
      while (words_sent - mode_start < 50) begin
        w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
        h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 5);
        d = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4);
        set_volume(w, h, d);
        vol_len = clamp_dim(w, 256) * clamp_dim(h, 256) * clamp_dim(d, DepthMax);
        repeat ($urandom_range(1, 3)) begin
          send_random(vol_len);
          if (!paused) begin
            // hold the sender until the total is back
            drain_quiet();
            paused = 1'b1;
          end
        end
        // leave a volume unfinished now and then; the next write restarts it
        if ($urandom_range(7) == 0) send_random($urandom_range(1, vol_len));
      end
    end

    // largest and out-of-range sizes, one axis at a time, then a small 2x2 plane
    set_volume(511, 1, 1);
    send_random(256);
    set_volume(1, 511, 1);
    send_random(256);
    set_volume(1, 1, 2047);
    send_random(40);
    set_volume(1, 1, 1024);
    send_random(30);
    set_volume(2, 2, 1);
    send_random(8);

    drain_quiet();
    $display("%0d voxels sent and %0d totals checked", words_sent, totals_seen);
    $display("covered: edge sizes, clamped sizes, random volumes, three idle modes");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
